// ----- design/psc_pkg.sv -----
// Package for the parabolic sine/cosine unit: operation codes, angle
// constants in 1/256 degree and the reciprocals for the divide-by-constant steps.
// No dependencies.
package psc_pkg;

   typedef enum logic {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } op_type;

   // angle format: degrees with 8 fraction bits
   localparam int DEG_FRAC     = 8;
   localparam int QUARTER_TURN = 90 << DEG_FRAC;    // 23040
   localparam int HALF_TURN    = 180 << DEG_FRAC;   // 46080
   localparam int FULL_TURN    = 360 << DEG_FRAC;   // 92160

   // FULL_TURN = 45 * 2^11: the low 11 bits pass, the rest is reduced mod 45
   localparam int LO_W     = 11;
   localparam int WRAP_MOD = 45;

   // HALF_TURN^2 = 2025 * 2^20
   localparam int DIV_A = 2025;
   localparam int DIV_B = 2 * DIV_A;

   // floor reciprocals; each estimate is low by at most one
   localparam longint M_DIV_A = (longint'(1) << 30) / DIV_A;
   localparam longint M_DIV_B = (longint'(1) << 24) / DIV_B;
   localparam longint M_DIV_5 = (longint'(1) << 29) / 5;

   localparam int WORK_FRAC = 30;
   localparam longint ONE_Q30 = longint'(1) << WORK_FRAC;

   localparam int NSTAGE = 14;

endpackage

// ----- design/parabolic_sine_cosine_unit.sv -----
// Parabolic sine/cosine unit, fixed-point datapath in 14 register stages.
// Depends on psc_pkg.
//
//  channel | direction | ports                                  | handshake
//  --------+-----------+----------------------------------------+-----------
//  req     | in        | req_operation, req_angle_deg           | valid/ready
//  rsp     | out       | rsp_value                              | valid/ready
//
// One transfer per cycle sustained while the output is not stalled. The stage
// count is set by the four reciprocal multiplies
// (wrap mod 45, /2025, /4050, /5) and the two square-type multiplies.
// Reset (synchronous, active high) clears the valid bits only.
// The whole pipe holds while the output register is full and not taken;
// req_ready follows that hold, so a stall drops and repeats nothing.
module parabolic_sine_cosine_unit #(
   parameter int ANGLE_WIDTH  = 24,
   parameter int RESULT_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic signed [ANGLE_WIDTH-1:0]  req_angle_deg,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [RESULT_WIDTH-1:0] rsp_value
);

   localparam int AW  = ANGLE_WIDTH;
   localparam int RW  = RESULT_WIDTH;
   localparam int F   = RW - 1;                  // output fraction bits
   localparam int VW  = AW + 1;                  // angle plus quarter turn
   localparam int QW  = VW - psc_pkg::LO_W;      // turn count in 2^11 units
   localparam int QNW = QW + 1;                  // after offset, unsigned
   localparam int NS  = psc_pkg::NSTAGE;

   // multiple of 45 that lifts any QW-bit signed value to nonnegative
   localparam logic [QNW-1:0] K45 = QNW'(psc_pkg::WRAP_MOD * (2 ** (QW - 5)));
   localparam logic [QNW-1:0] M45 = QNW'((longint'(1) << QNW) / psc_pkg::WRAP_MOD);

   localparam logic [16:0] HALF17 = 17'(psc_pkg::HALF_TURN);
   localparam logic [16:0] FULL17 = 17'(psc_pkg::FULL_TURN);
   localparam logic [30:0] ONE31  = 31'(psc_pkg::ONE_Q30);
   localparam logic [30:0] RND    = 31'(longint'(1) << (29 - F));

   // ---------------------------------------------------------------- control
   logic [NS-1:0] vld_ff;
   logic          en;

   assign en        = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------- stage A
   // add the quarter turn for cosine, split off the low 11 bits, offset the
   // turn count so the mod-45 step sees an unsigned value
   logic signed [VW-1:0] a_v;
   logic        [QNW-1:0] a_qn_in, a_qn_ff;
   logic [psc_pkg::LO_W-1:0] a_lo_ff;
   psc_pkg::op_type a_op_in, a_op_ff;

   always_comb begin
      a_op_in = psc_pkg::op_type'(req_operation);
      a_v     = {req_angle_deg[AW-1], req_angle_deg}
              + ((a_op_in == psc_pkg::OP_COSINE) ? VW'(psc_pkg::QUARTER_TURN) : VW'(0));
      a_qn_in = {a_v[VW-1], a_v[VW-1:psc_pkg::LO_W]} + K45;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_qn_ff <= a_qn_in;
         a_lo_ff <= a_v[psc_pkg::LO_W-1:0];
         a_op_ff <= a_op_in;
      end
   end

   // ---------------------------------------------------------------- stage B
   logic [2*QNW-1:0] b_prod;
   logic [QNW-1:0]   b_qhat_ff, b_qn_ff;
   logic [psc_pkg::LO_W-1:0] b_lo_ff;
   psc_pkg::op_type b_op_ff;

   assign b_prod = a_qn_ff * M45;

   always_ff @(posedge clock) begin
      if (en) begin
         b_qhat_ff <= b_prod[2*QNW-1:QNW];
         b_qn_ff   <= a_qn_ff;
         b_lo_ff   <= a_lo_ff;
         b_op_ff   <= a_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage C
   logic [QNW-1:0] c_rr_full;
   logic [6:0]     c_rr_ff;
   logic [psc_pkg::LO_W-1:0] c_lo_ff;
   psc_pkg::op_type c_op_ff;

   assign c_rr_full = b_qn_ff - QNW'(b_qhat_ff * QNW'(psc_pkg::WRAP_MOD));

   always_ff @(posedge clock) begin
      if (en) begin
         c_rr_ff <= c_rr_full[6:0];
         c_lo_ff <= b_lo_ff;
         c_op_ff <= b_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage D
   // finish mod 45, rebuild the angle in [0, 360), fold into [-180, 180)
   logic [6:0]  d_r;
   logic [16:0] d_m, d_a;
   logic        d_neg;
   logic [15:0] d_a_ff;
   logic        d_neg_ff;
   psc_pkg::op_type d_op_ff;

   always_comb begin
      d_r   = (c_rr_ff >= 7'(psc_pkg::WRAP_MOD)) ? c_rr_ff - 7'(psc_pkg::WRAP_MOD) : c_rr_ff;
      d_m   = {d_r[5:0], c_lo_ff};
      d_neg = (d_m >= HALF17);
      d_a   = d_neg ? FULL17 - d_m : d_m;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_a_ff   <= d_a[15:0];
         d_neg_ff <= d_neg;
         d_op_ff  <= c_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage E
   // p = a * (180 deg - a), below 2^30
   logic [31:0] e_prod;
   logic [29:0] e_p_ff;
   logic        e_neg_ff;
   psc_pkg::op_type e_op_ff;

   assign e_prod = d_a_ff * (16'(psc_pkg::HALF_TURN) - d_a_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         e_p_ff   <= e_prod[29:0];
         e_neg_ff <= d_neg_ff;
         e_op_ff  <= d_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage F
   // u = p / 2025, estimate
   logic [49:0] f_prod;
   logic [18:0] f_u_ff;
   logic [29:0] f_p_ff;
   logic        f_neg_ff;
   psc_pkg::op_type f_op_ff;

   assign f_prod = e_p_ff * 20'(psc_pkg::M_DIV_A);

   always_ff @(posedge clock) begin
      if (en) begin
         f_u_ff   <= f_prod[48:30];
         f_p_ff   <= e_p_ff;
         f_neg_ff <= e_neg_ff;
         f_op_ff  <= e_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage G
   logic [29:0] g_w_full;
   logic [11:0] g_w_ff;
   logic [18:0] g_u_ff;
   logic        g_neg_ff;
   psc_pkg::op_type g_op_ff;

   assign g_w_full = f_p_ff - 30'(f_u_ff * 30'(psc_pkg::DIV_A));

   always_ff @(posedge clock) begin
      if (en) begin
         g_w_ff   <= g_w_full[11:0];
         g_u_ff   <= f_u_ff;
         g_neg_ff <= f_neg_ff;
         g_op_ff  <= f_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage H
   // fix u, then t = (8192*w + 2025) / 4050, estimate
   logic        h_fix;
   logic [11:0] h_w;
   logic [18:0] h_u;
   logic [23:0] h_v2;
   logic [36:0] h_prod;
   logic [11:0] h_t_ff;
   logic [23:0] h_v2_ff;
   logic [18:0] h_u_ff;
   logic        h_neg_ff;
   psc_pkg::op_type h_op_ff;

   always_comb begin
      h_fix  = (g_w_ff >= 12'(psc_pkg::DIV_A));
      h_w    = h_fix ? g_w_ff - 12'(psc_pkg::DIV_A) : g_w_ff;
      h_u    = g_u_ff + 19'(h_fix);
      h_v2   = {h_w[10:0], 13'b0} + 24'(psc_pkg::DIV_A);
      h_prod = h_v2 * 13'(psc_pkg::M_DIV_B);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_t_ff   <= h_prod[35:24];
         h_v2_ff  <= h_v2;
         h_u_ff   <= h_u;
         h_neg_ff <= g_neg_ff;
         h_op_ff  <= g_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage I
   // Y30 = 4096*u + t, at most 2^30
   logic [23:0] i_rem;
   logic [11:0] i_t;
   logic [30:0] i_y_ff;
   logic        i_neg_ff;
   psc_pkg::op_type i_op_ff;

   always_comb begin
      i_rem = h_v2_ff - 24'(h_t_ff * 24'(psc_pkg::DIV_B));
      i_t   = h_t_ff + 12'(i_rem >= 24'(psc_pkg::DIV_B));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i_y_ff   <= {h_u_ff, 12'b0} + 31'(i_t);
         i_neg_ff <= h_neg_ff;
         i_op_ff  <= h_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage J
   // refinement term Y * (1 - Y), Q.60, at most 2^58
   logic [61:0] j_prod;
   logic [58:0] j_t_ff;
   logic [30:0] j_y_ff;
   logic        j_neg_ff;
   psc_pkg::op_type j_op_ff;

   assign j_prod = i_y_ff * (ONE31 - i_y_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         j_t_ff   <= j_prod[58:0];
         j_y_ff   <= i_y_ff;
         j_neg_ff <= i_neg_ff;
         j_op_ff  <= i_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage K
   // 0.225 = 9 / (5 * 8): x = 9*t >> 33, then divide by 5
   logic [61:0] k_nine;
   logic [28:0] k_x_ff;
   logic [30:0] k_y_ff;
   logic        k_neg_ff;
   psc_pkg::op_type k_op_ff;

   assign k_nine = {j_t_ff, 3'b0} + 62'(j_t_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         k_x_ff   <= k_nine[61:33];
         k_y_ff   <= j_y_ff;
         k_neg_ff <= j_neg_ff;
         k_op_ff  <= j_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage L
   logic [55:0] l_prod;
   logic [26:0] l_q_ff;
   logic [28:0] l_x_ff;
   logic [30:0] l_y_ff;
   logic        l_neg_ff;
   psc_pkg::op_type l_op_ff;

   assign l_prod = k_x_ff * 27'(psc_pkg::M_DIV_5);

   always_ff @(posedge clock) begin
      if (en) begin
         l_q_ff   <= l_prod[55:29];
         l_x_ff   <= k_x_ff;
         l_y_ff   <= k_y_ff;
         l_neg_ff <= k_neg_ff;
         l_op_ff  <= k_op_ff;
      end
   end

   // ---------------------------------------------------------------- stage M
   // apply the correction (sine only) and round to F fraction bits
   logic [28:0] m_rem;
   logic [30:0] m_corr, m_s, m_rnd;
   logic [F:0]  m_r_ff;
   logic        m_neg_ff;

   always_comb begin
      m_rem  = l_x_ff - 29'(l_q_ff * 29'd5);
      m_corr = 31'(l_q_ff) + 31'(m_rem >= 29'd5);
      m_s    = (l_op_ff == psc_pkg::OP_SINE) ? l_y_ff - m_corr : l_y_ff;
      m_rnd  = m_s + RND;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_r_ff   <= m_rnd[30:30-F];
         m_neg_ff <= l_neg_ff;
      end
   end

   // ---------------------------------------------------------------- stage N
   // saturate full scale to 2^F-1, apply sign
   logic [F-1:0]  n_mag;
   logic [RW-1:0] n_val;
   logic [RW-1:0] rsp_value_ff;

   always_comb begin
      n_mag = m_r_ff[F] ? {F{1'b1}} : m_r_ff[F-1:0];
      n_val = m_neg_ff ? RW'(0) - {1'b0, n_mag} : {1'b0, n_mag};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= n_val;
      end
   end

   assign rsp_value = signed'(rsp_value_ff);

   // ---------------------------------------------------------------- checks
   // turn count residue after the first estimate stays below twice 45
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (c_rr_ff < 7'(2 * psc_pkg::WRAP_MOD)))
      else $error("wrap residue out of range");

   // folded magnitude never exceeds a half turn
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (d_a_ff <= 16'(psc_pkg::HALF_TURN)))
      else $error("folded angle out of range");

   // parabola magnitude is at most 1.0
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[8] |-> (i_y_ff <= ONE31))
      else $error("parabola magnitude above one");

   // ready only drops while a result waits at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("pipeline held without output stall");

   // reset empties the pipe
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ----- dv/parabolic_sine_cosine_unit_tb.sv -----
// Testbench for parabolic_sine_cosine_unit: directed and random angles for sine
// and cosine, scored against a local fixed-point model. Depends on psc_pkg.
module parabolic_sine_cosine_unit_tb;

   localparam int ANGLE_W   = 24;
   localparam int RESULT_W  = 16;
   localparam int PIPE_LAT  = 14;
   localparam int STALL_MAX = 1000;
   localparam int LONG_HOLD = 48;
   localparam int MAX_PRINT = 20;

   // angle units: 1/256 degree
   localparam longint T_QUARTER = 64'd23040;
   localparam longint T_HALF    = 64'd46080;
   localparam longint T_FULL    = 64'd92160;
   localparam longint unsigned HALF_SQ   = 64'd46080 * 64'd46080;
   localparam longint unsigned UNIT_Q30  = 64'd1 << 30;
   localparam longint unsigned BLEND_DEN = 64'd40 << 30;
   localparam int OUT_FRAC = RESULT_W - 1;
   localparam longint unsigned MAG_MAX = (64'd1 << OUT_FRAC) - 1;

   typedef struct {
      psc_pkg::op_type            op;
      logic signed [ANGLE_W-1:0]  angle;
      logic signed [RESULT_W-1:0] value;
   } trig_item_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_operation = 1'b0;
   logic signed [ANGLE_W-1:0]  req_angle_deg = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RESULT_W-1:0] rsp_value;

   trig_item_type trig_q[$];
   int  errors = 0;
   int  sine_count = 0;
   int  cosine_count = 0;
   int  checked_count = 0;
   int  stall_cycles = 0;
   int  hold_cycles = 0;
   bit  idle_en = 1'b1;

   parabolic_sine_cosine_unit #(
      .ANGLE_WIDTH  (ANGLE_W),
      .RESULT_WIDTH (RESULT_W)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_angle_deg (req_angle_deg),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Q1.15 sine (with the 0.225 blend) or cosine (parabola only) of an angle
   function automatic logic signed [RESULT_W-1:0] sine_cosine_of(
      psc_pkg::op_type op, logic signed [ANGLE_W-1:0] angle);
      longint            turn;
      longint unsigned   a;
      longint unsigned   y;
      longint unsigned   t;
      logic              neg;
      logic signed [RESULT_W-1:0] res;
      turn = longint'(angle) + ((op == psc_pkg::OP_COSINE) ? T_QUARTER : 64'd0);
      turn = turn % T_FULL;
      if (turn < 0) turn += T_FULL;
      if (turn >= T_HALF) turn -= T_FULL;
      neg = turn < 0;
      a = neg ? longint'(-turn) : longint'(turn);
      y = (((a * (T_HALF - a)) << 32) + HALF_SQ / 2) / HALF_SQ;
      if (op == psc_pkg::OP_SINE) begin
         t = y * (UNIT_Q30 - y);
         y = y - (64'd9 * t) / BLEND_DEN;
      end
      y = (y + (64'd1 << (29 - OUT_FRAC))) >> (30 - OUT_FRAC);
      if (y > MAG_MAX) y = MAG_MAX;
      res = y[RESULT_W-1:0];
      if (neg) res = -res;
      return res;
   endfunction

   task automatic report(string what);
      errors++;
      if (errors <= MAX_PRINT) $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // input side: every req transfer queues its expected value
   always @(posedge clock) begin
      trig_item_type it;
      if (!reset && req_valid && req_ready) begin
         it.op    = psc_pkg::op_type'(req_operation);
         it.angle = req_angle_deg;
         it.value = sine_cosine_of(it.op, it.angle);
         trig_q.push_back(it);
         if (it.op == psc_pkg::OP_SINE) sine_count++;
         else cosine_count++;
      end
   end

   // output side: compare each rsp transfer with the oldest expectation
   always @(posedge clock) begin
      trig_item_type it;
      if (!reset && rsp_valid && rsp_ready) begin
         if (trig_q.size() == 0) begin
            report($sformatf("rsp value %0d with nothing outstanding", rsp_value));
         end else begin
            it = trig_q.pop_front();
            checked_count++;
            if (rsp_value !== it.value)
               report($sformatf("%s angle %0d: value %0d, want %0d",
                                it.op.name(), it.angle, rsp_value, it.value));
         end
      end
   end

   // watchdog: cycles without any transfer on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("timeout: %0d cycles without a transfer", STALL_MAX);
         $display("parabolic_sine_cosine_unit_tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random backpressure bursts, plus one long hold on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles - 1) @(negedge clock);
            hold_cycles = 0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 6);
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // one req transfer; returns at the accepting edge with valid still high
   task automatic send_item(psc_pkg::op_type op, logic signed [ANGLE_W-1:0] angle);
      int gap;
      gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_angle_deg <= angle;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (trig_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int     sel;
      longint v;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         v = longint'($urandom());
      else if (sel < 7)
         v = longint'($urandom_range(0, 368640)) - 64'd184320;
      else
         v = longint'($urandom_range(0, 16)) * T_QUARTER - 8 * T_QUARTER
             + longint'($urandom_range(0, 8)) - 4;
      return v[ANGLE_W-1:0];
   endfunction

   // axis angles, wrap boundaries, full-scale saturation, field extremes
   task automatic test_directed();
      psc_pkg::op_type ops[2];
      ops[0] = psc_pkg::OP_SINE;
      ops[1] = psc_pkg::OP_COSINE;
      foreach (ops[i]) begin
         send_item(ops[i], 24'sd0);
         send_item(ops[i], 24'sd1);
         send_item(ops[i], -24'sd1);
         send_item(ops[i], 24'sd23040);          // +90, sine saturates
         send_item(ops[i], -24'sd23040);
         send_item(ops[i], 24'sd46080);          // +180 wraps to -180
         send_item(ops[i], -24'sd46080);
         send_item(ops[i], 24'sd11520);          // 45
         send_item(ops[i], 24'sd69120);          // 270
         send_item(ops[i], 24'sd8388607);
         send_item(ops[i], -24'sd8388608);
      end
      drain();
   endtask

   task automatic test_random(int count);
      repeat (count) send_item(psc_pkg::op_type'($urandom_range(0, 1)), pick_angle());
   endtask

   // hold rsp long enough for the pipe to fill while req keeps offering
   task automatic test_backpressure();
      bit saved;
      saved = idle_en;
      idle_en = 1'b0;
      hold_cycles = LONG_HOLD;
      test_random(40);
      idle_en = saved;
   endtask

   // sender pauses until everything has come back, then sends again with random gaps
   task automatic test_pause_and_burst();
      drain();
      test_random(20);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(220);
      test_backpressure();
      test_pause_and_burst();
      test_random(230);
      idle_en = 1'b0;
      test_random(120);

      drain();
      repeat (PIPE_LAT + 6) @(posedge clock);
      $display("covered %0d sine and %0d cosine transfers, %0d results scored",
               sine_count, cosine_count, checked_count);
      $display("incl. axis/wrap/saturation angles, long rsp stall, drained pause");
      if (errors == 0) begin
         $display("parabolic_sine_cosine_unit_tb: clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("parabolic_sine_cosine_unit_tb: errors");
      end
      $finish;
   end

endmodule
